// ===== rtl/pcr_pkg.sv =====
// ----------------------------------------------------------------------------
// pcr_pkg
// Shared types and constants for the Philox 4x32 counter generator.
// ----------------------------------------------------------------------------
package pcr_pkg;

  localparam int unsigned ROUND_COUNT = 10;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned SEED_W  = 64;
  localparam int unsigned LIMIT_W = 33;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [WORD_W-1:0] WEYL_0 = 32'h9E3779B9;
  localparam logic [WORD_W-1:0] WEYL_1 = 32'hBB67AE85;
  localparam logic [WORD_W-1:0] MULT_0 = 32'hD2511F53;
  localparam logic [WORD_W-1:0] MULT_1 = 32'hCD9E8D57;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED_VALUE  = 1'b0,
    REG_COUNT_LIMIT = 1'b1
  } pcr_reg_t;

  // Counter block plus the key for the round it is about to enter
  typedef struct packed {
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w2;
    logic [WORD_W-1:0] w3;
    logic [WORD_W-1:0] key0;
    logic [WORD_W-1:0] key1;
  } pcr_blk_t;

endpackage

// ===== rtl/pcr_round.sv =====
// ----------------------------------------------------------------------------
// pcr_round
// One registered Philox 4x32 round: two 32x32 products, swap, key XOR, bump.
// ----------------------------------------------------------------------------
module pcr_round
  import pcr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  pcr_blk_t in_blk,
  output logic     out_valid,
  output pcr_blk_t out_blk
);

  logic [2*WORD_W-1:0] prod0;
  logic [2*WORD_W-1:0] prod1;
  pcr_blk_t            blk_nxt;
  pcr_blk_t            blk_r;
  logic                valid_r;

  assign prod0 = (2*WORD_W)'(in_blk.w0) * (2*WORD_W)'(MULT_0);
  assign prod1 = (2*WORD_W)'(in_blk.w2) * (2*WORD_W)'(MULT_1);

  always_comb begin
    blk_nxt.w0   = prod1[2*WORD_W-1:WORD_W] ^ in_blk.w1 ^ in_blk.key0;
    blk_nxt.w1   = prod1[WORD_W-1:0];
    blk_nxt.w2   = prod0[2*WORD_W-1:WORD_W] ^ in_blk.w3 ^ in_blk.key1;
    blk_nxt.w3   = prod0[WORD_W-1:0];
    blk_nxt.key0 = in_blk.key0 + WEYL_0;
    blk_nxt.key1 = in_blk.key1 + WEYL_1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  // Payload carries no reset; valid qualifies it
  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

  assign out_valid = valid_r;
  assign out_blk   = blk_r;

endmodule

// ===== rtl/philox_counter_rng.sv =====
// ----------------------------------------------------------------------------
// philox_counter_rng
// Counter-based random generator: Philox 4x32 over (index, 0, 0, 0).
// ----------------------------------------------------------------------------
// A new counter index is taken every clock cycle (busy never rises) and its
// 64-bit result appears after the entry stage and the round stages, marked
// by a one-cycle out_valid strobe. The pipeline has one register stage per
// Philox round, each holding its own pair of 32x32 multipliers, plus the
// entry stage that checks the index and forms the key.
// The receiver cannot stall: take out_random_value in the cycle out_valid is
// high. An index at or above count_limit produces no transaction at all, so
// results leave in index-acceptance order with gaps where items were
// dropped. Write seed_value and count_limit only while no transaction is in
// flight.
// ----------------------------------------------------------------------------
module philox_counter_rng
  import pcr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // input channel
  input  logic                 start,
  output logic                 busy,
  input  logic [WORD_W-1:0]    in_counter_index,
  // result channel
  output logic                 out_valid,
  output logic [2*WORD_W-1:0]  out_random_value
);

  // Configuration registers
  logic [SEED_W-1:0]  seed_value_r;
  logic [LIMIT_W-1:0] count_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_value_r  <= '0;
      count_limit_r <= '0;
    end else if (cfg_we) begin
      unique case (pcr_reg_t'(cfg_index))
        REG_SEED_VALUE:  seed_value_r  <= cfg_wdata[SEED_W-1:0];
        REG_COUNT_LIMIT: count_limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline never stalls, so a new index is always welcome
  assign busy = 1'b0;

  // Entry stage: range check, build the counter block and first-round key
  logic     in_hit;
  logic     entry_valid_r;
  pcr_blk_t entry_blk_nxt;
  pcr_blk_t entry_blk_r;

  assign in_hit = start && !busy &&
                  ({1'b0, in_counter_index} < count_limit_r);

  always_comb begin
    entry_blk_nxt.w0   = in_counter_index;
    entry_blk_nxt.w1   = '0;
    entry_blk_nxt.w2   = '0;
    entry_blk_nxt.w3   = '0;
    entry_blk_nxt.key0 = seed_value_r[WORD_W-1:0] ^ WEYL_0;
    entry_blk_nxt.key1 = seed_value_r[SEED_W-1:WORD_W] ^ WEYL_1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= 1'b0;
    end else begin
      // drop out-of-range indices here; nothing downstream sees them
      entry_valid_r <= in_hit;
    end
  end

  always_ff @(posedge clk) begin
    entry_blk_r <= entry_blk_nxt;
  end

  // Round stages: one register stage per round, key advanced in each
  logic     stage_valid [ROUND_COUNT+1];
  pcr_blk_t stage_blk   [ROUND_COUNT+1];

  assign stage_valid[0] = entry_valid_r;
  assign stage_blk[0]   = entry_blk_r;

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    pcr_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stage_valid[r]),
      .in_blk    (stage_blk[r]),
      .out_valid (stage_valid[r+1]),
      .out_blk   (stage_blk[r+1])
    );
  end

  // Word zero in the upper half, word one in the lower half
  assign out_valid        = stage_valid[ROUND_COUNT];
  assign out_random_value = {stage_blk[ROUND_COUNT].w0, stage_blk[ROUND_COUNT].w1};

endmodule
